// ===== hw/rtl/contiguous_page_range_allocator_assert.svh =====
// Assertion helpers shared by the allocator modules.
`ifndef CONTIGUOUS_PAGE_RANGE_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_PAGE_RANGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, masked while reset is low
`define CPRA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpra: same-cycle check failed");

// Next-cycle implication, masked while reset is low
`define CPRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpra: next-cycle check failed");

`endif

// ===== hw/rtl/cpra_pkg.sv =====
package cpra_pkg;

    // Default geometry
    localparam int PAGES_PER_TBL_DEF = 1024;
    localparam int NUM_TABLES_DEF    = 8;

    // Present map is held as 32-bit words
    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;

    // Field widths
    localparam int COUNT_W    = 11;
    localparam int PAGE_NUM_W = 13;
    localparam int VADDR_W    = 32;

    // 4 MiB per table, 4 KiB per page
    localparam int TABLE_SHIFT = 22;
    localparam int PAGE_SHIFT  = 12;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [COUNT_W-1:0]    page_count;
        logic                  kernel_request;
        logic [PAGE_NUM_W-1:0] page_number;
    } t_in_item;

    typedef struct packed {
        logic               ok;
        logic [VADDR_W-1:0] vaddr;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic clr;
        logic div_step;
        logic free_rd;
        logic free_wr;
        logic scan_start;
        logic scan;
        logic next_tbl;
        logic found;
        logic mark;
        logic push;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic cnt_bad;
        logic div_last;
        logic free_oor;
        logic hit;
        logic tbl_end;
        logic last_tbl;
        logic mark_done;
        logic out_free;
    } t_stat;

endpackage

// ===== hw/rtl/cpra_ram.sv =====
module cpra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/cpra_ctrl.sv =====
`include "contiguous_page_range_allocator_assert.svh"

module cpra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  cpra_pkg::t_stat i_st,
    output logic            o_in_ready,
    output cpra_pkg::t_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_CLEAR    = 10'b00_0000_0001,
        S_IDLE     = 10'b00_0000_0010,
        S_DISPATCH = 10'b00_0000_0100,
        S_DIV      = 10'b00_0000_1000,
        S_FCHK     = 10'b00_0001_0000,
        S_FREE_WR  = 10'b00_0010_0000,
        S_SCAN     = 10'b00_0100_0000,
        S_FOUND    = 10'b00_1000_0000,
        S_MARK     = 10'b01_0000_0000,
        S_RESP     = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_st.is_free) begin
                    n_state = S_DIV;
                end else if (i_st.cnt_bad) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_st.div_last) begin
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                if (i_st.free_oor) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.free_rd = 1'b1;
                    n_state       = S_FREE_WR;
                end
            end
            S_FREE_WR: begin
                o_cmd.free_wr = 1'b1;
                n_state       = S_RESP;
            end
            S_SCAN: begin
                if (i_st.hit) begin
                    o_cmd.scan = 1'b1;
                    n_state    = S_FOUND;
                end else if (i_st.tbl_end) begin
                    if (i_st.last_tbl) begin
                        n_state = S_RESP;
                    end else begin
                        o_cmd.next_tbl = 1'b1;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_FOUND: begin
                o_cmd.found = 1'b1;
                n_state     = S_MARK;
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                if (i_st.mark_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_st.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    `CPRA_ASSERT_IMPL(a_push_has_room, i_clk, i_rst_n, o_cmd.push, i_st.out_free)
    `CPRA_ASSERT_NEXT(a_load_dispatch, i_clk, i_rst_n, o_cmd.load, r_state == S_DISPATCH)
    `CPRA_ASSERT_IMPL(a_hit_not_end, i_clk, i_rst_n, r_state == S_SCAN && i_st.hit, !i_st.tbl_end)

endmodule

// ===== hw/rtl/cpra_dp.sv =====
`include "contiguous_page_range_allocator_assert.svh"

module cpra_dp #(
    parameter int PAGES_PER_TBL = cpra_pkg::PAGES_PER_TBL_DEF,
    parameter int NUM_TABLES    = cpra_pkg::NUM_TABLES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpra_pkg::t_cmd      i_cmd,
    input  cpra_pkg::t_in_item  i_in_data,
    input  logic                i_out_ready,
    output cpra_pkg::t_stat     o_st,
    output logic                o_out_valid,
    output cpra_pkg::t_out_item o_out_data
);

    localparam int W         = cpra_pkg::WORD_BITS;
    localparam int WSH       = cpra_pkg::WORD_SHIFT;
    localparam int CW        = cpra_pkg::COUNT_W;
    localparam int PNW       = cpra_pkg::PAGE_NUM_W;
    localparam int VW        = cpra_pkg::VADDR_W;
    localparam int WPT       = (PAGES_PER_TBL + W - 1) / W;
    localparam int DEPTH     = NUM_TABLES * WPT;
    localparam int AW        = $clog2(DEPTH);
    localparam int WIW       = (WPT > 1) ? $clog2(WPT) : 1;
    localparam int ICW       = $clog2(WPT + 1);
    localparam int PGW       = WIW + WSH;
    localparam int TBW       = $clog2(NUM_TABLES);
    localparam int DCW       = 1;
    localparam int LAST_BITS = PAGES_PER_TBL - (WPT - 1) * W;

    // Reciprocal of the table size, exact for every page number of PNW bits
    localparam int RCP_SHIFT = 24;
    localparam int RCP_MUL   = ((1 << RCP_SHIFT) + PAGES_PER_TBL - 1) / PAGES_PER_TBL;
    localparam int RCP_W     = RCP_SHIFT - $clog2(PAGES_PER_TBL) + 1;
    localparam int PRW       = PNW + RCP_W;

    // Item registers
    logic                    r_op;
    logic                    r_kern;
    logic [CW-1:0]           r_len;
    logic                    r_res_ok;
    logic [VW-1:0]           r_res_vaddr;

    // Clearing pass
    logic [AW-1:0]           r_clr_addr;

    // Divider for the free path
    logic [PNW-1:0]          r_div_num;
    logic [PNW-1:0]          r_div_rem;
    logic [PNW-1:0]          r_div_q;
    logic [DCW-1:0]          r_div_cnt;

    // Scan
    logic [TBW-1:0]          r_tbl;
    logic [AW-1:0]           r_base;
    logic [ICW-1:0]          r_iss;
    logic                    r_dat_valid;
    logic [WIW-1:0]          r_dat_wrd;
    logic [CW-1:0]           r_carry;
    logic [PGW-1:0]          r_fnd_e;
    logic [PGW-1:0]          r_fnd_s;

    // Marking
    logic [ICW-1:0]          r_mk_iss;
    logic                    r_mk_dat_valid;
    logic [WIW-1:0]          r_mk_dat_wrd;

    // Output register
    logic                    r_out_valid;
    cpra_pkg::t_out_item     r_out_data;

    // Combinational
    logic [W-1:0]            rd_data;
    logic                    ram_rd_en;
    logic [AW-1:0]           ram_rd_addr;
    logic                    ram_wr_en;
    logic [AW-1:0]           ram_wr_addr;
    logic [W-1:0]            ram_wr_data;
    logic                    dat_last;
    logic [W-1:0]            valid_mask;
    logic [W-1:0]            free_bits;
    logic [CW-1:0]           run_len [W];
    logic [W-1:0]            hit_vec;
    logic [WSH-1:0]          hit_pos;
    logic                    scan_issue;
    logic                    mk_issue;
    logic [WIW-1:0]          mk_last_wrd;
    logic [W-1:0]            mark_mask;
    logic [AW-1:0]           free_addr;
    logic [PRW-1:0]          div_prod;
    logic [PNW-1:0]          div_q_n;
    logic [PNW-1:0]          div_qp;
    logic [PNW-1:0]          div_rem_n;
    logic [PGW-1:0]          fnd_s_n;
    logic                    rem_in_tbl;
    logic                    mk_in_run;

    cpra_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (rd_data)
    );

    // Padding bits past the table end count as occupied
    assign dat_last = (r_dat_wrd == WIW'(WPT - 1));
    always_comb begin
        for (int j = 0; j < W; j++) begin
            valid_mask[j] = !(dat_last && (j >= LAST_BITS));
        end
    end
    assign free_bits = ~rd_data & valid_mask;

    // Length of the free run ending at each bit, carried in from earlier words
    always_comb begin : scan_run
        logic           seen;
        logic [WSH-1:0] last_occ;
        for (int j = 0; j < W; j++) begin
            seen     = 1'b0;
            last_occ = '0;
            for (int i = 0; i <= j; i++) begin
                if (!free_bits[i]) begin
                    seen     = 1'b1;
                    last_occ = WSH'(i);
                end
            end
            run_len[j] = seen ? CW'(WSH'(j) - last_occ) : r_carry + CW'(j + 1);
            hit_vec[j] = (run_len[j] >= r_len);
        end
    end

    // Lowest bit at which the run reaches the wanted length
    always_comb begin
        hit_pos = '0;
        for (int j = W - 1; j >= 0; j--) begin
            if (hit_vec[j]) begin
                hit_pos = WSH'(j);
            end
        end
    end

    assign scan_issue  = (r_iss < ICW'(WPT));
    assign mk_last_wrd = r_fnd_e[PGW-1:WSH];
    assign mk_issue    = (r_mk_iss <= ICW'(mk_last_wrd));
    assign fnd_s_n     = r_fnd_e - PGW'(r_len) + PGW'(1);

    // Bits of the word in flight that fall inside the found run
    always_comb begin : mark_bits
        logic [PGW-1:0] pg;
        for (int j = 0; j < W; j++) begin
            pg           = {r_mk_dat_wrd, WSH'(j)};
            mark_mask[j] = (pg >= r_fnd_s) && (pg <= r_fnd_e);
        end
    end

    // Word holding the page to free
    assign free_addr = AW'(r_div_q[TBW-1:0]) * AW'(WPT) + AW'(r_div_rem[PNW-1:WSH]);

    // Table by reciprocal multiply, then page as the remainder
    assign div_prod  = PRW'(r_div_num) * PRW'(RCP_MUL);
    assign div_q_n   = PNW'(div_prod[PRW-1:RCP_SHIFT]);
    assign div_qp    = r_div_q * PNW'(PAGES_PER_TBL);
    assign div_rem_n = r_div_num - div_qp;

    // Memory port selection
    always_comb begin
        ram_rd_en = (i_cmd.scan && scan_issue) || (i_cmd.mark && mk_issue) || i_cmd.free_rd;
        if (i_cmd.mark) begin
            ram_rd_addr = r_base + AW'(r_mk_iss[WIW-1:0]);
        end else if (i_cmd.free_rd) begin
            ram_rd_addr = free_addr;
        end else begin
            ram_rd_addr = r_base + AW'(r_iss[WIW-1:0]);
        end

        ram_wr_en = i_cmd.clr || i_cmd.free_wr || (i_cmd.mark && r_mk_dat_valid);
        if (i_cmd.clr) begin
            ram_wr_addr = r_clr_addr;
            ram_wr_data = '0;
        end else if (i_cmd.free_wr) begin
            ram_wr_addr = free_addr;
            ram_wr_data = rd_data & ~(W'(1) << r_div_rem[WSH-1:0]);
        end else begin
            ram_wr_addr = r_base + AW'(r_mk_dat_wrd);
            ram_wr_data = rd_data | mark_mask;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr     <= '0;
            r_dat_valid    <= 1'b0;
            r_mk_dat_valid <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.scan_start || i_cmd.next_tbl) begin
                r_dat_valid <= 1'b0;
            end else if (i_cmd.scan) begin
                r_dat_valid <= scan_issue;
            end
            if (i_cmd.found) begin
                r_mk_dat_valid <= 1'b0;
            end else if (i_cmd.mark) begin
                r_mk_dat_valid <= mk_issue;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        // Item capture
        if (i_cmd.load) begin
            r_op        <= i_in_data.op;
            r_kern      <= i_in_data.kernel_request;
            r_len       <= i_in_data.page_count;
            r_div_num   <= i_in_data.page_number;
            r_div_rem   <= '0;
            r_div_q     <= '0;
            r_div_cnt   <= '0;
            r_res_ok    <= 1'b0;
            r_res_vaddr <= '0;
        end

        // Division in two steps: quotient first, remainder from it next
        if (i_cmd.div_step) begin
            if (r_div_cnt == '0) begin
                r_div_q <= div_q_n;
            end else begin
                r_div_rem <= div_rem_n;
            end
            r_div_cnt <= r_div_cnt + DCW'(1);
        end

        if (i_cmd.free_wr) begin
            r_res_ok <= 1'b1;
        end

        // Scan sequencing
        if (i_cmd.scan_start) begin
            r_tbl   <= r_kern ? '0 : TBW'(1);
            r_base  <= r_kern ? '0 : AW'(WPT);
            r_iss   <= '0;
            r_carry <= '0;
        end else if (i_cmd.next_tbl) begin
            r_tbl   <= r_tbl + TBW'(1);
            r_base  <= r_base + AW'(WPT);
            r_iss   <= '0;
            r_carry <= '0;
        end else if (i_cmd.scan) begin
            if (scan_issue) begin
                r_iss <= r_iss + ICW'(1);
            end
            r_dat_wrd <= r_iss[WIW-1:0];
            if (r_dat_valid) begin
                r_carry <= run_len[W-1];
                r_fnd_e <= {r_dat_wrd, hit_pos};
            end
        end

        // Run found: work out its start and the address to return
        if (i_cmd.found) begin
            r_fnd_s     <= fnd_s_n;
            r_mk_iss    <= ICW'(fnd_s_n[PGW-1:WSH]);
            r_res_ok    <= 1'b1;
            r_res_vaddr <= (VW'(r_tbl) << cpra_pkg::TABLE_SHIFT)
                         + (VW'(fnd_s_n) << cpra_pkg::PAGE_SHIFT);
        end

        // Read-modify-write over the words of the run
        if (i_cmd.mark) begin
            if (mk_issue) begin
                r_mk_iss <= r_mk_iss + ICW'(1);
            end
            r_mk_dat_wrd <= r_mk_iss[WIW-1:0];
        end

        if (i_cmd.push) begin
            r_out_data.ok    <= r_res_ok;
            r_out_data.vaddr <= r_res_vaddr;
        end
    end

    // Status towards the controller
    always_comb begin
        o_st.clr_last  = (r_clr_addr == AW'(DEPTH - 1));
        o_st.is_free   = (r_op == cpra_pkg::OP_FREE);
        o_st.cnt_bad   = (r_len == '0) || (r_len > CW'(PAGES_PER_TBL));
        o_st.div_last  = (r_div_cnt == DCW'(1));
        o_st.free_oor  = (r_div_q >= PNW'(NUM_TABLES));
        o_st.hit       = r_dat_valid && (|hit_vec);
        o_st.tbl_end   = r_dat_valid && dat_last && !(|hit_vec);
        o_st.last_tbl  = r_kern || (r_tbl == TBW'(NUM_TABLES - 1));
        o_st.mark_done = r_mk_dat_valid && (r_mk_dat_wrd == mk_last_wrd);
        o_st.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checked conditions
    assign rem_in_tbl = (r_div_rem < PNW'(PAGES_PER_TBL));
    assign mk_in_run  = (r_mk_dat_wrd >= r_fnd_s[PGW-1:WSH]) && (r_mk_dat_wrd <= mk_last_wrd);

    `CPRA_ASSERT_IMPL(a_rem_below_tbl, i_clk, i_rst_n, i_cmd.free_rd, rem_in_tbl)
    `CPRA_ASSERT_IMPL(a_carry_below_len, i_clk, i_rst_n, i_cmd.scan, r_carry < r_len)
    `CPRA_ASSERT_IMPL(a_mark_in_run, i_clk, i_rst_n, i_cmd.mark && r_mk_dat_valid, mk_in_run)

endmodule

// ===== hw/rtl/contiguous_page_range_allocator.sv =====
// Contiguous page range allocator.
// Input channel i_in_valid / o_in_ready carries one request per transfer:
// allocate page_count consecutive pages (kernel table 0, or user tables 1
// upward, first fit in each table) or free one page by global page number.
// Output channel o_out_valid / i_out_ready returns exactly one result per
// request: ok and the virtual address of the first page of the range.
// One request is worked on at a time; the present map is a 32-bit-wide RAM
// read one word per cycle. A free splits the page number into table and
// page by reciprocal multiply; a zero or oversized count is refused with
// no search. Allocate reads each table in turn up to the word where the
// run ends, passing over tables that hold no such run, then marks the
// words the run spans; a failed search reads every table open to the
// request. The result is offered as o_in_ready rises again.
// After reset a clearing pass writes every map word to zero; o_in_ready
// stays low until it ends. The result sits in an output register: a
// stalled receiver holds it there while the next request is taken and
// worked on, and that request completes only once the register has been
// emptied.
module contiguous_page_range_allocator #(
    parameter int PAGES_PER_TBL = cpra_pkg::PAGES_PER_TBL_DEF,
    parameter int NUM_TABLES    = cpra_pkg::NUM_TABLES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cpra_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cpra_pkg::t_out_item o_out_data
);

    cpra_pkg::t_cmd  cmd;
    cpra_pkg::t_stat st;

    // Sequencer
    cpra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (st),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Map, divider, scan and result register
    cpra_dp #(
        .PAGES_PER_TBL (PAGES_PER_TBL),
        .NUM_TABLES    (NUM_TABLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_st        (st),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sim/tb_contiguous_page_range_allocator.sv =====
`timescale 1ns / 100ps

module tb_contiguous_page_range_allocator;

    import cpra_pkg::*;

    localparam int PAGES        = PAGES_PER_TBL_DEF;
    localparam int TABLES       = NUM_TABLES_DEF;
    localparam int TOTAL_PAGES  = PAGES * TABLES;
    localparam int RANDOM_ITEMS = 650;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_WAIT  = 300;

    // One request waiting for the driver, with its pacing flags
    typedef struct {
        t_in_item req;
        bit       drain_first;
        bit       no_gap;
    } t_pending_request;

    // Result we expect back; vaddr carries no meaning on a free
    typedef struct {
        t_out_item res;
        bit        addr_checked;
    } t_expected_result;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    t_pending_request pending_requests[$];
    t_expected_result open_results[$];

    // Predicted present map, one bit per virtual page
    bit page_present [TOTAL_PAGES];

    int  send_gap      = 0;
    int  recv_gap      = 0;
    int  quiet_cycles  = 0;
    bit  steady_flow   = 1'b0;
    bit  hold_for_drain = 1'b0;
    bit  steady_phase  = 1'b0;
    int  n_random      = 0;
    int  n_errors      = 0;
    int  n_alloc_ok    = 0;
    int  n_alloc_fail  = 0;
    int  n_frees       = 0;
    int  n_results     = 0;

    contiguous_page_range_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // First page of the earliest run of len free pages in table tbl, or -1
    function automatic int first_free_run(int tbl, int len);
        int run;
        int start;
        int p;
        run   = 0;
        start = 0;
        if (len == 0 || len > PAGES) return -1;
        for (p = 0; p < PAGES; p++) begin
            if (!page_present[tbl * PAGES + p]) begin
                if (run == 0) start = p;
                run++;
                if (run == len) return start;
            end else begin
                run = 0;
            end
        end
        return -1;
    endfunction

    // Work out the result of one request and update the predicted map
    task automatic predict_request(input t_in_item req, output t_expected_result exp_res);
        int tbl;
        int last_tbl;
        int start;
        int i;
        exp_res.res          = '0;
        exp_res.addr_checked = 1'b1;
        if (req.op == OP_FREE) begin
            exp_res.addr_checked = 1'b0;
            n_frees++;
            if (int'(req.page_number) < TOTAL_PAGES) begin
                page_present[req.page_number] = 1'b0;
                exp_res.res.ok = 1'b1;
            end
        end else begin
            // kernel searches table 0, user tables 1 upward, first fit in each
            tbl      = req.kernel_request ? 0 : 1;
            last_tbl = req.kernel_request ? 1 : TABLES;
            start    = -1;
            while (tbl < last_tbl && start < 0) begin
                start = first_free_run(tbl, int'(req.page_count));
                if (start < 0) tbl++;
            end
            if (start >= 0) begin
                for (i = 0; i < int'(req.page_count); i++)
                    page_present[tbl * PAGES + start + i] = 1'b1;
                exp_res.res.ok    = 1'b1;
                exp_res.res.vaddr = (32'(tbl) << TABLE_SHIFT) + (32'(start) << PAGE_SHIFT);
                n_alloc_ok++;
            end else begin
                n_alloc_fail++;
            end
        end
    endtask

    // Append one request to the driver's queue
    task automatic queue_request(input logic op, input int count, input bit kern,
                                 input int page);
        t_pending_request item;
        item.req.op             = op;
        item.req.page_count     = COUNT_W'(count);
        item.req.kernel_request = kern;
        item.req.page_number    = PAGE_NUM_W'(page);
        item.drain_first        = hold_for_drain;
        item.no_gap             = steady_phase;
        hold_for_drain          = 1'b0;
        pending_requests.push_back(item);
        n_random++;
    endtask

    task automatic queue_alloc(input int count, input bit kern);
        queue_request(OP_ALLOC, count, kern, $urandom_range(0, TOTAL_PAGES - 1));
    endtask

    task automatic queue_free(input int page);
        queue_request(OP_FREE, $urandom_range(0, 2047), $urandom_range(0, 1), page);
    endtask

    // Mostly small runs, a few up to a whole table
    function automatic int draw_page_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(1, 4);
        if (r < 80) return $urandom_range(5, 32);
        if (r < 93) return $urandom_range(33, 256);
        if (r < 97) return $urandom_range(257, PAGES - 1);
        return PAGES;
    endfunction

    // A page currently believed present, searched from a random start
    function automatic int some_present_page();
        int base;
        int k;
        base = $urandom_range(0, TOTAL_PAGES - 1);
        for (k = 0; k < TOTAL_PAGES; k++)
            if (page_present[(base + k) % TOTAL_PAGES]) return (base + k) % TOTAL_PAGES;
        return -1;
    endfunction

    // Request driver: predicts on each transfer, then presents the next item
    always @(posedge i_clk) begin : request_driver
        t_pending_request nxt;
        t_expected_result exp_res;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_request(i_in_data, exp_res);
                open_results.push_back(exp_res);
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the item until the transfer
            end else if (send_gap != 0) begin
                i_in_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].drain_first && open_results.size() != 0)) begin
                nxt = pending_requests.pop_front();
                i_in_data   <= nxt.req;
                i_in_valid  <= 1'b1;
                send_gap    <= nxt.no_gap ? 0 : $urandom_range(0, 3);
                steady_flow <= nxt.no_gap;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each transfer against the oldest expectation
    always @(posedge i_clk) begin : result_monitor
        t_expected_result exp_res;
        int stall;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_gap    <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (open_results.size() == 0) begin
                    $error("unexpected result: ok=%0b vaddr=%h", o_out_data.ok, o_out_data.vaddr);
                    n_errors++;
                end else begin
                    exp_res = open_results.pop_front();
                    if (o_out_data.ok !== exp_res.res.ok) begin
                        $error("ok mismatch: expected %0b, actual %0b",
                               exp_res.res.ok, o_out_data.ok);
                        n_errors++;
                    end
                    if (exp_res.addr_checked && o_out_data.vaddr !== exp_res.res.vaddr) begin
                        $error("vaddr mismatch: expected %h, actual %h",
                               exp_res.res.vaddr, o_out_data.vaddr);
                        n_errors++;
                    end
                end
                // stall for the next result is counted once it is offered
                stall = steady_flow ? 0 : $urandom_range(0, 3);
                recv_gap    <= stall;
                i_out_ready <= (stall == 0);
            end else if (!i_out_ready && o_out_valid) begin
                if (recv_gap > 1) recv_gap <= recv_gap - 1;
                else i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        int pick;
        int page;
        int len;
        int k;
        int next_drain_at;
        int next_phase_at;

        // Directed: count limits, full tables, holes at table edges,
        // ignored fields, freeing an already free page
        queue_request(OP_ALLOC, 0, 1'b1, 0);
        queue_request(OP_ALLOC, 2047, 1'b1, TOTAL_PAGES - 1);
        queue_alloc(PAGES + 1, 1'b1);
        queue_alloc(PAGES, 1'b1);
        queue_alloc(1, 1'b1);
        queue_request(OP_FREE, 2047, 1'b1, 0);
        queue_request(OP_FREE, 0, 1'b0, PAGES - 1);
        queue_alloc(2, 1'b1);
        queue_alloc(1, 1'b1);
        queue_alloc(1, 1'b1);
        queue_alloc(PAGES, 1'b0);
        queue_alloc(1, 1'b0);
        queue_alloc(PAGES, 1'b0);
        queue_alloc(PAGES - 1, 1'b0);
        for (k = 4; k < TABLES; k++) queue_alloc(PAGES, 1'b0);
        queue_alloc(1, 1'b0);
        queue_free(TOTAL_PAGES - 1);
        queue_free(TOTAL_PAGES - 1);
        queue_alloc(2, 1'b0);
        queue_alloc(1, 1'b0);
        queue_free(PAGES * 3 + 17);
        queue_free(PAGES * 3 + 18);
        queue_alloc(2, 1'b0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Random traffic: mostly well-formed allocate and free, some noise
        n_random      = 0;
        next_drain_at = 0;
        next_phase_at = 0;
        while (n_random < RANDOM_ITEMS) begin
            while (pending_requests.size() >= 2) @(posedge i_clk);
            if (n_random >= next_drain_at) begin
                hold_for_drain = 1'b1;
                next_drain_at += 150;
            end
            if (n_random >= next_phase_at) begin
                steady_phase = ($urandom_range(0, 3) == 0);
                next_phase_at += 80;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                queue_alloc(draw_page_count(), $urandom_range(0, 3) == 0);
            end else if (pick < 75) begin
                page = some_present_page();
                queue_free(page < 0 ? $urandom_range(0, TOTAL_PAGES - 1) : page);
            end else if (pick < 85) begin
                // release a stretch of neighbouring pages
                page = some_present_page();
                if (page < 0) page = $urandom_range(0, TOTAL_PAGES - 1);
                len = $urandom_range(2, 48);
                for (k = 0; k < len && page + k < TOTAL_PAGES; k++) queue_free(page + k);
            end else if (pick < 92) begin
                queue_free($urandom_range(0, TOTAL_PAGES - 1));
            end else if (pick < 96) begin
                queue_alloc(0, $urandom_range(0, 1));
            end else begin
                queue_alloc($urandom_range(PAGES + 1, 2047), $urandom_range(0, 1));
            end
        end

        // Drain, then let any stray result show up
        while (pending_requests.size() != 0 || i_in_valid || open_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("covered %0d results: %0d allocations granted, %0d refused, %0d frees",
                 n_results, n_alloc_ok, n_alloc_fail, n_frees);
        $display("directed table-edge cases, then random first-fit traffic with gaps and stalls");
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cpra_pkg.sv
hw/rtl/cpra_ram.sv
hw/rtl/cpra_ctrl.sv
hw/rtl/cpra_dp.sv
hw/rtl/contiguous_page_range_allocator.sv
sim/tb_contiguous_page_range_allocator.sv
